>>> sv/mst_pkg.sv
`timescale 1ns / 1ps

package mst_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int RESULT_CAP    = 8;
   localparam int CNT_W         = $clog2(RESULT_CAP + 1);

   localparam int TIME_W   = 32;
   localparam int ACT_W    = 2;
   localparam int TIDX_W   = 4;
   localparam int STATUS_W = 3;
   localparam int OSLOT_W  = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_START  = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_POLL   = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STARTED     = 3'd0,
      ST_FULL        = 3'd1,
      ST_CANCELLED   = 3'd2,
      ST_CANCEL_FAIL = 3'd3,
      ST_FIRED       = 3'd4,
      ST_NONE        = 3'd5
   } status_type;

   typedef struct packed {
      logic accept;
      logic scan_next;
      logic claim;
      logic full;
      logic cancel;
      logic fire;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic cur_active;
      logic cur_due;
      logic scan_last;
      logic cap_next;
      logic pend_valid;
      logic out_free;
   } ctl_sts_type;

endpackage

>>> sv/mst_req_if.sv
`timescale 1ns / 1ps

interface mst_req_if;
   logic                        valid;
   logic                        ready;
   logic [mst_pkg::ACT_W-1:0]   action;
   logic [mst_pkg::TIME_W-1:0]  now_time;
   logic [mst_pkg::TIME_W-1:0]  delay;
   logic                        repeat_req;
   logic [mst_pkg::TIDX_W-1:0]  timer_index;

   modport source (
      output valid, action, now_time, delay, repeat_req, timer_index,
      input  ready
   );

   modport sink (
      input  valid, action, now_time, delay, repeat_req, timer_index,
      output ready
   );
endinterface

>>> sv/mst_rsp_if.sv
`timescale 1ns / 1ps

interface mst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mst_pkg::STATUS_W-1:0]  status;
   logic [mst_pkg::OSLOT_W-1:0]   slot;
   logic                          last;

   modport source (
      output valid, status, slot, last,
      input  ready
   );

   modport sink (
      input  valid, status, slot, last,
      output ready
   );
endinterface

>>> sv/mst_datapath.sv
`timescale 1ns / 1ps

module mst_datapath #(
   parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mst_pkg::ctl_cmd_type          cmd,
   output mst_pkg::ctl_sts_type          sts,
   input  logic [mst_pkg::TIME_W-1:0]    req_now_time,
   input  logic [mst_pkg::TIME_W-1:0]    req_delay,
   input  logic                          req_repeat_req,
   input  logic [mst_pkg::TIDX_W-1:0]    req_timer_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [mst_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mst_pkg::OSLOT_W-1:0]   rsp_slot,
   output logic                          rsp_last
);
   import mst_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // latched word
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    delay_ff;
   logic                 rep_ff;
   logic [TIDX_W-1:0]    tidx_ff;

   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] periodic_ff, periodic_in;
   logic [SLOT_W-1:0]    pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [TIME_W-1:0]    slot_deadline_ff [NUM_SLOTS];
   logic [TIME_W-1:0]    slot_period_ff [NUM_SLOTS];
   logic [TIME_W-1:0]    dl_rd_ff;
   logic [TIME_W-1:0]    per_rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [OSLOT_W-1:0]   rsp_slot_ff;
   logic                 rsp_last_ff;

   logic [TIME_W-1:0]    diff;
   logic                 due;
   logic [SLOT_W-1:0]    cidx;
   logic                 cancel_ok;
   logic                 out_free;
   logic                 mem_we;
   logic [TIME_W-1:0]    mem_wdata;

   logic                 push;
   status_type           push_status;
   logic [SLOT_W-1:0]    push_slot;
   logic                 push_last;

   assign diff      = now_ff - dl_rd_ff;
   assign due       = active_ff[idx_ff] && !diff[TIME_W-1];
   assign cidx      = SLOT_W'(tidx_ff);
   assign cancel_ok = (32'(tidx_ff) < 32'(NUM_SLOTS)) && active_ff[cidx];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.cur_active = active_ff[idx_ff];
      sts.cur_due    = due;
      sts.scan_last  = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
      sts.cap_next   = (cnt_ff == CNT_W'(RESULT_CAP - 1));
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   assign mem_we    = cmd.claim || (cmd.fire && periodic_ff[idx_ff]);
   assign mem_wdata = cmd.claim ? (now_ff + delay_ff) : (dl_rd_ff + per_rd_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = '0;
      end else if (cmd.scan_next) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      active_in   = active_ff;
      periodic_in = periodic_ff;
      if (cmd.claim) begin
         active_in[idx_ff]   = 1'b1;
         periodic_in[idx_ff] = rep_ff;
      end
      if (cmd.cancel && cancel_ok) begin
         active_in[cidx] = 1'b0;
      end
      if (cmd.fire && !periodic_ff[idx_ff]) begin
         active_in[idx_ff] = 1'b0;
      end
   end

   // a fired slot is held back until it is known whether it is the last one
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in        = cnt_ff;
      if (cmd.accept) begin
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end else if (cmd.fire) begin
         pend_in       = idx_ff;
         pend_valid_in = 1'b1;
         cnt_in        = cnt_ff + CNT_W'(1);
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      push        = 1'b0;
      push_status = ST_NONE;
      push_slot   = '0;
      push_last   = 1'b1;
      if (cmd.claim) begin
         push        = 1'b1;
         push_status = ST_STARTED;
         push_slot   = idx_ff;
      end else if (cmd.full) begin
         push        = 1'b1;
         push_status = ST_FULL;
      end else if (cmd.cancel) begin
         push        = 1'b1;
         push_status = cancel_ok ? ST_CANCELLED : ST_CANCEL_FAIL;
      end else if (cmd.fire && pend_valid_ff) begin
         push        = 1'b1;
         push_status = ST_FIRED;
         push_slot   = pend_ff;
         push_last   = 1'b0;
      end else if (cmd.flush) begin
         push = 1'b1;
         if (pend_valid_ff) begin
            push_status = ST_FIRED;
            push_slot   = pend_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         active_ff     <= '0;
         periodic_ff   <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         periodic_ff   <= periodic_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (cmd.accept) begin
         now_ff   <= req_now_time;
         delay_ff <= req_delay;
         rep_ff   <= req_repeat_req;
         tidx_ff  <= req_timer_index;
      end
      if (push) begin
         rsp_status_ff <= push_status;
         rsp_slot_ff   <= OSLOT_W'(push_slot);
         rsp_last_ff   <= push_last;
      end
   end

   // deadline and period memories, read one slot ahead of the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_deadline_ff[idx_ff] <= mem_wdata;
      end
      if (cmd.claim) begin
         slot_period_ff[idx_ff] <= delay_ff;
      end
      dl_rd_ff  <= slot_deadline_ff[idx_in];
      per_rd_ff <= slot_period_ff[idx_in];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> sv/mst_controller.sv
`timescale 1ns / 1ps

module mst_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [mst_pkg::ACT_W-1:0]  req_action,
   output logic                       req_ready,
   input  mst_pkg::ctl_sts_type       sts,
   output mst_pkg::ctl_cmd_type       cmd
);
   import mst_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_CANCEL = 5'b00100,
      S_POLL   = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_action)
                  ACT_START:  state_in = S_START;
                  ACT_CANCEL: state_in = S_CANCEL;
                  ACT_POLL:   state_in = S_POLL;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_START: begin
            if (!sts.cur_active) begin
               if (sts.out_free) begin
                  cmd.claim = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (sts.scan_last) begin
               if (sts.out_free) begin
                  cmd.full = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_CANCEL: begin
            if (sts.out_free) begin
               cmd.cancel = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_POLL: begin
            if (sts.cur_due) begin
               if (!sts.pend_valid || sts.out_free) begin
                  cmd.fire = 1'b1;
                  if (sts.cap_next || sts.scan_last) begin
                     state_in = S_FLUSH;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end
            end else if (sts.scan_last) begin
               state_in = S_FLUSH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/multi_slot_timer_scheduler.sv
`timescale 1ns / 1ps

// channel   dir   handshake           word
// req_bus   in    valid/ready         action, now_time, delay, repeat_req, timer_index
// rsp_bus   out   valid/ready         status, slot, last
//
// start scans the active flags one slot a cycle until it finds a free slot or the last one;
// poll walks the slots one a cycle, holding while a due slot waits for the output register,
// through the registered read port of the deadline and period memories
// synchronous reset clears slot flags, controller and output valid; memories are
// not cleared, a slot's deadline and period are used only once it is active
// results leave through one output register; a full register stalls the scan, and
// the next word is taken while the final result still waits

module multi_slot_timer_scheduler #(
   parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
   input logic        clock,
   input logic        reset,
   mst_req_if.sink    req_bus,
   mst_rsp_if.source  rsp_bus
);
   import mst_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   mst_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mst_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_now_time    (req_bus.now_time),
      .req_delay       (req_bus.delay),
      .req_repeat_req  (req_bus.repeat_req),
      .req_timer_index (req_bus.timer_index),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_status      (rsp_bus.status),
      .rsp_slot        (rsp_bus.slot),
      .rsp_last        (rsp_bus.last)
   );

   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.claim || cmd.full || cmd.cancel || cmd.flush || (cmd.fire && sts.pend_valid))
      |-> sts.out_free)
      else $error("result pushed into a busy output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready &&
       (req_bus.action == ACT_START || req_bus.action == ACT_CANCEL ||
        req_bus.action == ACT_POLL))
      |=> !req_bus.ready)
      else $error("word taken while previous word still in progress");

   a_flush_gives_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_bus.valid && rsp_bus.last))
      else $error("poll end did not present a final result");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mst_pkg::*;

   localparam int NSLOT = 8;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;
   localparam int WORDS_PER_PHASE = 45;
   localparam int LONG_HOLD = 120;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 30;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] delay;
      logic              repeat_req;
      logic [TIDX_W-1:0] timer_index;
      bit                wait_idle;
   } timer_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OSLOT_W-1:0]  slot;
      logic                last;
   } timer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mst_req_if req_bus ();
   mst_rsp_if rsp_bus ();

   multi_slot_timer_scheduler #(.NUM_SLOTS(NSLOT)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // driven copies of the block inputs
   logic              drv_valid       = 1'b0;
   logic [ACT_W-1:0]  drv_action      = '0;
   logic [TIME_W-1:0] drv_now_time    = '0;
   logic [TIME_W-1:0] drv_delay       = '0;
   logic              drv_repeat_req  = 1'b0;
   logic [TIDX_W-1:0] drv_timer_index = '0;
   logic              rsp_ready_q     = 1'b0;

   assign req_bus.valid       = drv_valid;
   assign req_bus.action      = drv_action;
   assign req_bus.now_time    = drv_now_time;
   assign req_bus.delay       = drv_delay;
   assign req_bus.repeat_req  = drv_repeat_req;
   assign req_bus.timer_index = drv_timer_index;
   assign rsp_bus.ready       = rsp_ready_q;

   timer_word_type   pending_q[$];
   timer_result_type sched_expect_q[$];
   timer_word_type   cur_word;
   timer_result_type exp_res;

   // predicted slot state
   bit                tmr_active   [NSLOT];
   bit                tmr_periodic [NSLOT];
   logic [TIME_W-1:0] tmr_deadline [NSLOT];
   logic [TIME_W-1:0] tmr_period   [NSLOT];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   logic [TIME_W-1:0] tick_now;

   function automatic timer_result_type mk_result(input status_type st, input int slot_num,
                                                  input logic last_flag);
      timer_result_type r;
      r.status = st;
      r.slot   = slot_num[OSLOT_W-1:0];
      r.last   = last_flag;
      return r;
   endfunction

   function automatic void predict_timer_word(input timer_word_type w);
      int fired_cnt;
      bit found;
      fired_cnt = 0;
      found = 0;
      case (w.action)
         ACT_START: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (!found && !tmr_active[i]) begin
                  found = 1;
                  tmr_active[i]   = 1;
                  tmr_periodic[i] = w.repeat_req;
                  tmr_deadline[i] = w.now_time + w.delay;
                  tmr_period[i]   = w.delay;
                  sched_expect_q.push_back(mk_result(ST_STARTED, i, 1'b1));
               end
            end
            if (!found)
               sched_expect_q.push_back(mk_result(ST_FULL, 0, 1'b1));
         end
         ACT_CANCEL: begin
            if (w.timer_index < NSLOT && tmr_active[w.timer_index]) begin
               tmr_active[w.timer_index] = 0;
               sched_expect_q.push_back(mk_result(ST_CANCELLED, 0, 1'b1));
            end else begin
               sched_expect_q.push_back(mk_result(ST_CANCEL_FAIL, 0, 1'b1));
            end
         end
         ACT_POLL: begin
            for (int i = 0; i < NSLOT; i++) begin
               if (fired_cnt < RESULT_CAP && tmr_active[i] &&
                   (w.now_time - tmr_deadline[i]) < HALF_RANGE) begin
                  if (tmr_periodic[i])
                     tmr_deadline[i] = tmr_deadline[i] + tmr_period[i];
                  else
                     tmr_active[i] = 0;
                  sched_expect_q.push_back(mk_result(ST_FIRED, i, 1'b0));
                  fired_cnt++;
               end
            end
            if (fired_cnt == 0)
               sched_expect_q.push_back(mk_result(ST_NONE, 0, 1'b1));
            else
               sched_expect_q[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic timer_word_type gen_timer_word();
      timer_word_type w;
      int pick;
      w = '0;
      pick = $urandom_range(99);
      tick_now = tick_now + $urandom_range(40);
      w.now_time = ($urandom_range(19) == 0) ? $urandom : tick_now;
      w.delay = ($urandom_range(9) == 0) ? $urandom : $urandom_range(120);
      w.repeat_req = 1'($urandom_range(1));
      w.timer_index = ($urandom_range(7) == 0) ? TIDX_W'($urandom_range(15))
                                                : TIDX_W'($urandom_range(NSLOT - 1));
      w.wait_idle = ($urandom_range(24) == 0);
      if (pick < 40)
         w.action = ACT_START;
      else if (pick < 60)
         w.action = ACT_CANCEL;
      else if (pick < 95)
         w.action = ACT_POLL;
      else
         w.action = ACT_UNUSED;
      return w;
   endfunction

   task automatic push_word(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] now_t,
                            input logic [TIME_W-1:0] dly, input logic rep,
                            input logic [TIDX_W-1:0] idx);
      timer_word_type w;
      w.action      = act;
      w.now_time    = now_t;
      w.delay       = dly;
      w.repeat_req  = rep;
      w.timer_index = idx;
      w.wait_idle   = 0;
      pending_q.push_back(w);
   endtask

   task automatic drain_pending();
      while (pending_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
      timer_word_type w;
      int n;
      n = 0;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold)
         hold_reqs++;
      while (n < WORDS_PER_PHASE) begin
         w = gen_timer_word();
         if (n == 0)
            w.wait_idle = 1;
         if (w.action != ACT_UNUSED)
            n++;
         pending_q.push_back(w);
      end
      drain_pending();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_timer_word(cur_word);
         if (!drv_valid || req_bus.ready) begin
            if (pending_q.size() != 0 &&
                !(pending_q[0].wait_idle && sched_expect_q.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               cur_word = pending_q.pop_front();
               drv_valid       <= 1'b1;
               drv_action      <= cur_word.action;
               drv_now_time    <= cur_word.now_time;
               drv_delay       <= cur_word.delay;
               drv_repeat_req  <= cur_word.repeat_req;
               drv_timer_index <= cur_word.timer_index;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sched_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: status %0d slot %0d last %0d",
                           rsp_bus.status, rsp_bus.slot, rsp_bus.last);
            end else begin
               exp_res = sched_expect_q.pop_front();
               if (rsp_bus.status !== exp_res.status || rsp_bus.slot !== exp_res.slot ||
                   rsp_bus.last !== exp_res.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                              exp_res.status, exp_res.slot, exp_res.last,
                              rsp_bus.status, rsp_bus.slot, rsp_bus.last);
               end
            end
         end
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready_q <= 1'b0;
         end else begin
            rsp_ready_q <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         tmr_active[i]   = 0;
         tmr_periodic[i] = 0;
         tmr_deadline[i] = '0;
         tmr_period[i]   = '0;
      end
      tick_now = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words, no idling
      push_word(ACT_POLL,   32'h0000_0000, 32'h0,         1'b0, 4'd0);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b0, 4'd0);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b0, 4'd8);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b1, 4'd15);
      push_word(ACT_START,  32'd100,       32'h0,         1'b1, 4'd0);
      push_word(ACT_START,  32'hFFFF_FFF0, 32'h20,        1'b1, 4'd0);
      push_word(ACT_START,  32'h0,         32'hFFFF_FFFF, 1'b0, 4'd0);
      push_word(ACT_START,  32'd1000,      32'h8000_0000, 1'b0, 4'd0);
      push_word(ACT_START,  32'd500,       32'd50,        1'b0, 4'd0);
      push_word(ACT_START,  32'h0,         32'h7FFF_FFFF, 1'b1, 4'd0);
      push_word(ACT_START,  32'hFFFF_FFFF, 32'd1,         1'b0, 4'd0);
      push_word(ACT_START,  32'd200,       32'd300,       1'b1, 4'd0);
      push_word(ACT_START,  32'd0,         32'd5,         1'b0, 4'd0);
      push_word(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
      push_word(ACT_POLL,   32'd100,       32'h0,         1'b0, 4'd0);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b0, 4'd7);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b0, 4'd7);
      push_word(ACT_POLL,   32'd550,       32'h0,         1'b0, 4'd0);
      push_word(ACT_POLL,   32'h8000_0064, 32'h0,         1'b0, 4'd0);
      push_word(ACT_POLL,   32'h8000_0063, 32'h0,         1'b0, 4'd0);
      push_word(ACT_POLL,   32'hFFFF_FFFF, 32'h0,         1'b0, 4'd0);
      push_word(ACT_CANCEL, 32'h0,         32'h0,         1'b0, 4'd0);
      push_word(ACT_POLL,   32'h0000_1000, 32'h0,         1'b0, 4'd0);
      drain_pending();

      run_phase(0, 0, 1);
      run_phase(57, 0, 0);
      run_phase(0, 57, 0);
      run_phase(26, 26, 0);

      @(negedge clock);
      while (drv_valid || sched_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && sched_expect_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
sv/mst_pkg.sv
sv/mst_req_if.sv
sv/mst_rsp_if.sv
sv/mst_datapath.sv
sv/mst_controller.sv
sv/multi_slot_timer_scheduler.sv
verif/tb_top.sv
